@@ rtl/core/lca_binary_lifting_macros.svh @@
// ----------------------------------------------------------------------------
// LCA binary lifting assertion macros
// Shared property shorthands for the checker of the LCA block.
// ----------------------------------------------------------------------------
`ifndef LCA_BINARY_LIFTING_MACROS_SVH
`define LCA_BINARY_LIFTING_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define LCABL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lca_binary_lifting: check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define LCABL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lca_binary_lifting: check failed");

`endif

@@ rtl/core/lcabl_pkg.sv @@
// ----------------------------------------------------------------------------
// LCA binary lifting package
// Beat types, function and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package lcabl_pkg;

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_BUILD = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_BUILD = 1'b1;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] first_node;
    logic [9:0] second_node;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [9:0] ancestor;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ZERO,
    S_SAN_RD,
    S_SAN_WR,
    S_LIFT_RD1,
    S_LIFT_RD2,
    S_LIFT_WR,
    S_DEP_RD,
    S_DEP_CHK,
    S_DEP_WR,
    S_Q_DU,
    S_Q_DV,
    S_Q_SW,
    S_Q_UP,
    S_Q_UP_WR,
    S_Q_EQ,
    S_Q_AU,
    S_Q_AV,
    S_Q_AC,
    S_Q_FIN,
    S_Q_FIN_WR,
    S_EMIT
  } state_t;

endpackage

@@ rtl/core/lca_binary_lifting.sv @@
// ----------------------------------------------------------------------------
// LCA binary lifting
// Lowest-common-ancestor engine over a rooted tree held in a 2^k ancestor
// table, driven by one memory read per step under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Beat            Use
//  -------  --------------------  --------------  ------------------------------
//  req      req_valid/req_ready   lcabl_pkg::req_t  load parent, build, query
//  rsp      rsp_valid/rsp_ready   lcabl_pkg::rsp_t  query answer, build done
//  cfg      APB psel/penable      32-bit data     node_count at byte address 0
//
// A load completes in the cycle it is accepted. Queries and builds are paced
// by the single read port of the ancestor table, one read per step, with the
// read data registered. Reset (synchronous, rst) clears the sequencer, the
// built flag and the output valid flag and sets node_count to 1; table
// contents stay undefined until loaded or built.
// A finished result waits in an output register while req_ready is high
// again; the sequencer only holds in its last step if that register is full.
//
module lca_binary_lifting #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  lcabl_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output lcabl_pkg::rsp_t rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import lcabl_pkg::*;

  // Node index width, level counter width and the compare width that covers
  // both the 10-bit fields and the node index.
  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = (NW > 10) ? NW : 10;
  localparam int AW = LW + NW;

  state_t state, state_next;

  logic [9:0]        node_count;
  logic              built, built_next;
  logic [NW-1:0]     j, j_next;
  logic [LW-1:0]     k, k_next;
  logic [NW-1:0]     x, x_next;
  logic [LEVELS-1:0] d, d_next;
  logic [NW-1:0]     u, u_next;
  logic [NW-1:0]     v, v_next;
  logic [LEVELS-1:0] du, du_next;
  logic [LEVELS-1:0] diff, diff_next;
  logic [NW-1:0]     au, au_next;
  rsp_t              res, res_next;

  // Ancestor table, addressed by {level, node}, and the depth store.
  logic [NW-1:0]     tab_mem [2**AW];
  logic [LEVELS-1:0] dep_mem [MAX_NODES];
  logic              tab_we;
  logic [AW-1:0]     tab_waddr, tab_raddr;
  logic [NW-1:0]     tab_wdata, tab_rdata;
  logic              dep_we;
  logic [NW-1:0]     dep_waddr, dep_raddr;
  logic [LEVELS-1:0] dep_rdata;

  logic [CW-1:0] cnt;
  logic          req_fire, cfg_write, emit_go;
  logic          load_ok, q_range_bad;
  logic          last_j, last_k;

  // Effective node count, clamped to MAX_NODES - 1, the largest node index.
  assign cnt = (CW'(node_count) > CW'(MAX_NODES - 1)) ? CW'(MAX_NODES - 1)
                                                      : CW'(node_count);

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_NODE_COUNT[0]) ? {22'd0, node_count} : 32'd0;
  assign emit_go   = !rsp_valid || rsp_ready;

  assign last_j = (CW'(j) == cnt);
  assign last_k = (k == LW'(LEVELS - 1));

  // A load is taken only for a child in 2..count and a distinct parent in
  // 1..count; anything else leaves the table alone.
  assign load_ok = (req.first_node >= 10'd2) && (CW'(req.first_node) <= cnt) &&
                   (req.second_node >= 10'd1) && (CW'(req.second_node) <= cnt) &&
                   (req.first_node != req.second_node);

  assign q_range_bad = (req.first_node == 10'd0) || (CW'(req.first_node) > cnt) ||
                       (req.second_node == 10'd0) || (CW'(req.second_node) > cnt);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req.func)
            FN_BUILD: state_next = S_ZERO;
            FN_QUERY: state_next = (!built || q_range_bad) ? S_EMIT : S_Q_DU;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_ZERO: begin
        if (last_k) begin
          state_next = (cnt == '0) ? S_EMIT : S_SAN_RD;
        end
      end
      S_SAN_RD:   state_next = S_SAN_WR;
      S_SAN_WR: begin
        if (last_j) begin
          state_next = (LEVELS > 1) ? S_LIFT_RD1 : S_DEP_RD;
        end else begin
          state_next = S_SAN_RD;
        end
      end
      S_LIFT_RD1: state_next = S_LIFT_RD2;
      S_LIFT_RD2: state_next = S_LIFT_WR;
      S_LIFT_WR:  state_next = (last_j && last_k) ? S_DEP_RD : S_LIFT_RD1;
      S_DEP_RD:   state_next = S_DEP_CHK;
      S_DEP_CHK:  state_next = (k == '0) ? S_DEP_WR : S_DEP_RD;
      S_DEP_WR:   state_next = last_j ? S_EMIT : S_DEP_RD;
      S_Q_DU:     state_next = S_Q_DV;
      S_Q_DV:     state_next = S_Q_SW;
      S_Q_SW:     state_next = S_Q_UP;
      S_Q_UP: begin
        if (diff[k]) begin
          state_next = S_Q_UP_WR;
        end else if (last_k) begin
          state_next = S_Q_EQ;
        end
      end
      S_Q_UP_WR:  state_next = last_k ? S_Q_EQ : S_Q_UP;
      S_Q_EQ:     state_next = (u == v) ? S_EMIT : S_Q_AU;
      S_Q_AU:     state_next = S_Q_AV;
      S_Q_AV:     state_next = S_Q_AC;
      S_Q_AC:     state_next = (k == '0) ? S_Q_FIN : S_Q_AU;
      S_Q_FIN:    state_next = S_Q_FIN_WR;
      S_Q_FIN_WR: state_next = S_EMIT;
      S_EMIT:     state_next = emit_go ? S_IDLE : S_EMIT;
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath and memory controls for each step.
  always_comb begin
    built_next = built;
    j_next     = j;
    k_next     = k;
    x_next     = x;
    d_next     = d;
    u_next     = u;
    v_next     = v;
    du_next    = du;
    diff_next  = diff;
    au_next    = au;
    res_next   = res;
    tab_we     = 1'b0;
    tab_waddr  = {k, j};
    tab_wdata  = '0;
    tab_raddr  = {k, j};
    dep_we     = 1'b0;
    dep_waddr  = j;
    dep_raddr  = u;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req.func)
            FN_LOAD: begin
              built_next = 1'b0;
              tab_we     = load_ok;
              tab_waddr  = {LW'(0), NW'(req.first_node)};
              tab_wdata  = NW'(req.second_node);
            end
            FN_BUILD: begin
              k_next   = '0;
              j_next   = NW'(1);
              res_next = '{result_kind: KIND_BUILD, ancestor: 10'd0, status: ST_OK};
            end
            FN_QUERY: begin
              u_next = NW'(req.first_node);
              v_next = NW'(req.second_node);
              if (!built) begin
                res_next = '{result_kind: KIND_QUERY, ancestor: 10'd0,
                             status: ST_NOT_BUILT};
              end else begin
                res_next = '{result_kind: KIND_QUERY, ancestor: 10'd0,
                             status: q_range_bad ? ST_RANGE : ST_OK};
              end
            end
            default: begin
            end
          endcase
        end
      end
      // The sentinel node 0 points to itself at every level.
      S_ZERO: begin
        tab_we    = 1'b1;
        tab_waddr = {k, NW'(0)};
        tab_wdata = '0;
        k_next    = k + LW'(1);
        if (last_k && cnt == '0) begin
          built_next = 1'b1;
        end
      end
      S_SAN_RD: begin
        tab_raddr = {LW'(0), j};
      end
      // The root and any stale parent above the count become the sentinel.
      S_SAN_WR: begin
        tab_waddr = {LW'(0), j};
        tab_wdata = '0;
        tab_we    = (j == NW'(1)) || (CW'(tab_rdata) > cnt);
        j_next    = last_j ? NW'(1) : j + NW'(1);
        if (last_j) begin
          k_next = (LEVELS > 1) ? LW'(1) : LW'(LEVELS - 1);
          x_next = NW'(1);
          d_next = '0;
        end
      end
      S_LIFT_RD1: begin
        tab_raddr = {k - LW'(1), j};
      end
      S_LIFT_RD2: begin
        tab_raddr = {k - LW'(1), tab_rdata};
      end
      S_LIFT_WR: begin
        tab_we    = 1'b1;
        tab_waddr = {k, j};
        tab_wdata = tab_rdata;
        if (last_j) begin
          j_next = NW'(1);
          if (last_k) begin
            x_next = NW'(1);
            d_next = '0;
          end else begin
            k_next = k + LW'(1);
          end
        end else begin
          j_next = j + NW'(1);
        end
      end
      S_DEP_RD: begin
        tab_raddr = {k, x};
      end
      S_DEP_CHK: begin
        if (tab_rdata != '0) begin
          x_next = tab_rdata;
          d_next = d | (LEVELS'(1) << k);
        end
        if (k != '0) begin
          k_next = k - LW'(1);
        end
      end
      S_DEP_WR: begin
        dep_we    = 1'b1;
        dep_waddr = j;
        j_next    = j + NW'(1);
        x_next    = j + NW'(1);
        d_next    = '0;
        k_next    = LW'(LEVELS - 1);
        if (last_j) begin
          built_next = 1'b1;
        end
      end
      S_Q_DU: begin
        dep_raddr = u;
      end
      S_Q_DV: begin
        du_next   = dep_rdata;
        dep_raddr = v;
      end
      // Put the deeper node in u and take the depth difference.
      S_Q_SW: begin
        if (du < dep_rdata) begin
          u_next    = v;
          v_next    = u;
          diff_next = dep_rdata - du;
        end else begin
          diff_next = du - dep_rdata;
        end
        k_next = '0;
      end
      S_Q_UP: begin
        tab_raddr = {k, u};
        if (!diff[k] && !last_k) begin
          k_next = k + LW'(1);
        end
      end
      S_Q_UP_WR: begin
        u_next = tab_rdata;
        if (!last_k) begin
          k_next = k + LW'(1);
        end
      end
      S_Q_EQ: begin
        res_next.ancestor = 10'(u);
        k_next            = LW'(LEVELS - 1);
      end
      S_Q_AU: begin
        tab_raddr = {k, u};
      end
      S_Q_AV: begin
        au_next   = tab_rdata;
        tab_raddr = {k, v};
      end
      S_Q_AC: begin
        if (au != tab_rdata) begin
          u_next = au;
          v_next = tab_rdata;
        end
        if (k != '0) begin
          k_next = k - LW'(1);
        end
      end
      S_Q_FIN: begin
        tab_raddr = {LW'(0), u};
      end
      S_Q_FIN_WR: begin
        res_next.ancestor = 10'(tab_rdata);
      end
      default: begin
      end
    endcase
    if (cfg_write && paddr[2] == REG_NODE_COUNT[0]) begin
      built_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata <= tab_mem[tab_raddr];
    if (dep_we) begin
      dep_mem[dep_waddr] <= d;
    end
    dep_rdata <= dep_mem[dep_raddr];
  end

  always_ff @(posedge clk) begin
    j    <= j_next;
    k    <= k_next;
    x    <= x_next;
    d    <= d_next;
    u    <= u_next;
    v    <= v_next;
    du   <= du_next;
    diff <= diff_next;
    au   <= au_next;
    res  <= res_next;
    if (state == S_EMIT && emit_go) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      built      <= 1'b0;
      node_count <= 10'd1;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      built <= built_next;
      if (cfg_write && paddr[2] == REG_NODE_COUNT[0]) begin
        node_count <= pwdata[9:0];
      end
      if (state == S_EMIT && emit_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/lcabl_checker.sv @@
// ----------------------------------------------------------------------------
// LCA binary lifting checker
// Port-level properties of the LCA block, bound to its top level.
// ----------------------------------------------------------------------------
`include "lca_binary_lifting_macros.svh"

module lcabl_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input lcabl_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input lcabl_pkg::rsp_t rsp
);
  import lcabl_pkg::*;

  `LCABL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `LCABL_ASSERT_IMP(a_build_clean, rsp_valid && rsp.result_kind == KIND_BUILD, rsp.status == ST_OK && rsp.ancestor == 10'd0)
  `LCABL_ASSERT_IMP(a_err_zero, rsp_valid && rsp.status != ST_OK, rsp.ancestor == 10'd0 && rsp.result_kind == KIND_QUERY && (rsp.status == ST_RANGE || rsp.status == ST_NOT_BUILT))
  `LCABL_ASSERT_NXT(a_busy, req_valid && req_ready && (req.func == FN_BUILD || req.func == FN_QUERY), !req_ready)

endmodule

bind lca_binary_lifting lcabl_checker u_lcabl_checker (.*);
